[rtl/core/qpv_pkg.sv]
// ----------------------------------------------------------------------------
// qpv_pkg
// Shared types and constants of the encoder position and velocity block.
// ----------------------------------------------------------------------------
package qpv_pkg;

    localparam int COUNTER_BITS_DEF = 16;
    localparam int INPUT_BITS       = 16;
    localparam int POS_BITS         = 32;
    localparam int TIME_BITS        = 32;
    localparam int INTERVAL_BITS    = 16;
    localparam int SCALE_BITS       = 20;
    localparam int PROD_BITS        = POS_BITS + SCALE_BITS + 1;
    localparam int CFG_IDX_BITS     = 1;
    localparam int CFG_DATA_BITS    = 32;

    localparam logic [CFG_IDX_BITS-1:0] REG_INTERVAL = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCALE    = 1'b1;

    localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = 16'd10;
    localparam logic [SCALE_BITS-1:0]    SCALE_RESET    = 20'd1000;

    typedef struct packed {
        logic signed [POS_BITS-1:0] pos_a;
        logic signed [POS_BITS-1:0] pos_b;
        logic signed [POS_BITS-1:0] delta_a;
        logic signed [POS_BITS-1:0] delta_b;
        logic                       clear_a;
        logic                       clear_b;
        logic                       update;
        logic [TIME_BITS-1:0]       elapsed;
    } t_job;

    typedef struct packed {
        logic signed [POS_BITS-1:0] pos_a;
        logic signed [POS_BITS-1:0] pos_b;
        logic signed [POS_BITS-1:0] vel_a;
        logic signed [POS_BITS-1:0] vel_b;
        logic                       updated;
    } t_result;

endpackage

[rtl/core/qpv_front.sv]
// ----------------------------------------------------------------------------
// qpv_front
// Accepts items, tracks positions and decides when velocity is recomputed.
// ----------------------------------------------------------------------------
module qpv_front #(
    parameter int COUNTER_BITS = qpv_pkg::COUNTER_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [qpv_pkg::TIME_BITS-1:0]       i_time_ms,
    input  logic [qpv_pkg::INPUT_BITS-1:0]      i_count_a,
    input  logic [qpv_pkg::INPUT_BITS-1:0]      i_count_b,
    input  logic                                i_clear_a,
    input  logic                                i_clear_b,
    input  logic [qpv_pkg::INTERVAL_BITS-1:0]   i_interval,
    output logic                                o_job_valid,
    input  logic                                i_job_ready,
    output qpv_pkg::t_job                       o_job
);
    import qpv_pkg::*;

    localparam int CB = COUNTER_BITS;
    localparam int SW = CB + 1;
    localparam logic signed [SW-1:0] HALF = SW'((64'd1 << (CB - 1)) - 64'd1);
    localparam logic signed [SW+1:0] FULL = (SW+2)'(64'd1 << CB);

    logic [CB-1:0]        r_last_a, r_last_b;
    logic [POS_BITS-1:0]  r_acc_a, r_acc_b, r_prev_a, r_prev_b;
    logic [TIME_BITS-1:0] r_last_t;
    logic [CB-1:0]        samp_a, samp_b;
    logic [POS_BITS-1:0]  n_acc_a, n_acc_b;
    logic [TIME_BITS-1:0] elapsed;
    logic                 upd, take;

    function automatic logic [POS_BITS-1:0] fold(input logic [CB-1:0] s,
                                                 input logic [CB-1:0] l);
        logic signed [SW+1:0] st;
        st = (SW+2)'($signed({2'b00, s})) - (SW+2)'($signed({2'b00, l}));
        if (st > (SW+2)'(HALF)) st = st - FULL;
        if (st < -(SW+2)'(HALF)) st = st + FULL;
        return POS_BITS'(st);
    endfunction

    assign samp_a  = CB'(i_count_a);
    assign samp_b  = CB'(i_count_b);
    assign n_acc_a = i_clear_a ? '0 : r_acc_a + fold(samp_a, r_last_a);
    assign n_acc_b = i_clear_b ? '0 : r_acc_b + fold(samp_b, r_last_b);
    assign elapsed = i_time_ms - r_last_t;
    assign upd     = (elapsed != '0) && (elapsed >= TIME_BITS'(i_interval));
    assign o_ready = !o_job_valid || i_job_ready;
    assign take    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_a <= '0; r_last_b <= '0;
            r_acc_a  <= '0; r_acc_b  <= '0;
            r_prev_a <= '0; r_prev_b <= '0;
            r_last_t <= '0;
            o_job_valid <= 1'b0;
        end else begin
            if (take) begin
                o_job_valid <= 1'b1;
                r_acc_a  <= n_acc_a;
                r_acc_b  <= n_acc_b;
                r_last_a <= i_clear_a ? '0 : samp_a;
                r_last_b <= i_clear_b ? '0 : samp_b;
                o_job.pos_a   <= n_acc_a;
                o_job.pos_b   <= n_acc_b;
                o_job.delta_a <= n_acc_a - (i_clear_a ? '0 : r_prev_a);
                o_job.delta_b <= n_acc_b - (i_clear_b ? '0 : r_prev_b);
                o_job.clear_a <= i_clear_a;
                o_job.clear_b <= i_clear_b;
                o_job.update  <= upd;
                o_job.elapsed <= elapsed;
                if (upd) begin
                    r_last_t <= i_time_ms;
                    r_prev_a <= n_acc_a;
                    r_prev_b <= n_acc_b;
                end else begin
                    if (i_clear_a) r_prev_a <= '0;
                    if (i_clear_b) r_prev_b <= '0;
                end
            end else if (o_job_valid && i_job_ready) begin
                o_job_valid <= 1'b0;
            end
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_valid && !i_job_ready |=> o_job_valid && $stable(o_job))
        else $error("job changed while stalled");
    a_elapsed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_valid && o_job.update |-> o_job.elapsed != '0)
        else $error("update with zero elapsed");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> o_job_valid)
        else $error("accepted item lost");

endmodule

[rtl/core/qpv_back.sv]
// ----------------------------------------------------------------------------
// qpv_back
// Computes velocities with one shared multiplier and a serial divider.
// ----------------------------------------------------------------------------
module qpv_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_job_valid,
    output logic                              o_job_ready,
    input  qpv_pkg::t_job                     i_job,
    input  logic [qpv_pkg::SCALE_BITS-1:0]    i_scale,
    output logic                              o_valid,
    input  logic                              i_ready,
    output qpv_pkg::t_result                  o_res
);
    import qpv_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_SAT  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;
    localparam int MAG_BITS = PROD_BITS - 1;
    localparam int CNT_BITS = $clog2(MAG_BITS + 1);

    logic [2:0]             r_state;
    logic                   r_ch;
    t_job                   r_job;
    logic signed [POS_BITS-1:0] r_vel_a, r_vel_b;
    logic [MAG_BITS-1:0]    r_quo;
    logic [TIME_BITS:0]     r_rem;
    logic                   r_neg;
    logic [CNT_BITS-1:0]    r_cnt;
    logic signed [PROD_BITS-1:0] prod;
    logic signed [POS_BITS-1:0]  delta;
    logic [TIME_BITS:0]     trial;
    logic signed [POS_BITS-1:0]  sat;

    assign delta = r_ch ? r_job.delta_b : r_job.delta_a;
    assign prod  = PROD_BITS'(delta) * $signed({1'b0, i_scale});
    assign trial = {r_rem[TIME_BITS-1:0], r_quo[MAG_BITS-1]} - {1'b0, r_job.elapsed};

    always_comb begin
        if (r_quo > MAG_BITS'({1'b0, {(POS_BITS-1){1'b1}}}) + MAG_BITS'(r_neg))
            sat = r_neg ? {1'b1, {(POS_BITS-1){1'b0}}} : {1'b0, {(POS_BITS-1){1'b1}}};
        else
            sat = r_neg ? -POS_BITS'(r_quo) : POS_BITS'(r_quo);
    end

    assign o_job_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            o_valid <= 1'b0;
            r_vel_a <= '0;
            r_vel_b <= '0;
        end else begin
            if (o_valid && i_ready && r_state != ST_OUT) o_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_job <= i_job;
                        r_ch  <= 1'b0;
                        if (i_job.clear_a) r_vel_a <= '0;
                        if (i_job.clear_b) r_vel_b <= '0;
                        r_state <= i_job.update ? ST_MUL : ST_OUT;
                    end
                end
                ST_MUL: begin
                    r_neg <= prod[PROD_BITS-1];
                    r_quo <= prod[PROD_BITS-1] ? MAG_BITS'(-prod) : MAG_BITS'(prod);
                    r_rem <= '0;
                    r_cnt <= CNT_BITS'(MAG_BITS);
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (!trial[TIME_BITS]) begin
                        r_rem <= trial;
                        r_quo <= {r_quo[MAG_BITS-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[TIME_BITS-1:0], r_quo[MAG_BITS-1]};
                        r_quo <= {r_quo[MAG_BITS-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNT_BITS'(1)) r_state <= ST_SAT;
                end
                ST_SAT: begin
                    if (r_ch) r_vel_b <= sat; else r_vel_a <= sat;
                    r_ch    <= 1'b1;
                    r_state <= r_ch ? ST_OUT : ST_MUL;
                end
                ST_OUT: begin
                    if (!o_valid || i_ready) begin
                        o_valid       <= 1'b1;
                        o_res.pos_a   <= r_job.pos_a;
                        o_res.pos_b   <= r_job.pos_b;
                        o_res.vel_a   <= r_vel_a;
                        o_res.vel_b   <= r_vel_b;
                        o_res.updated <= r_job.update;
                        r_state       <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_res))
        else $error("result changed while stalled");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_cnt != '0)
        else $error("divider count underflow");
    a_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_OUT && r_job.clear_a |-> r_vel_a == '0)
        else $error("cleared channel has velocity");

endmodule

[rtl/core/quadrature_position_velocity.sv]
// ----------------------------------------------------------------------------
// quadrature_position_velocity
// Two-channel encoder position accumulator with velocity estimate.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready) carries a ms timestamp, two raw counter
// samples and two clear flags; output channel (o_valid/i_ready) returns one
// result per item: both positions, both velocities and an update flag.
// The front stage folds sample steps into the positions and
// hands a job to the back stage through a one-entry register.
// The back stage runs one signed multiply and a 52-step restoring divider
// per channel when velocity is due, and accepts no new job until it has
// handed out the result of the current one.
// Configuration writes (i_cfg_valid/o_cfg_ready) are always taken:
// index 0 is the update interval, index 1 the velocity scale.
// Reset clears accumulators and velocities; interval 10 ms, scale 1000.
// A stalled receiver holds the result; the back stage finishes one more job,
// the front holds one more, then the input stalls.
// ----------------------------------------------------------------------------
module quadrature_position_velocity #(
    parameter int COUNTER_BITS = qpv_pkg::COUNTER_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [qpv_pkg::TIME_BITS-1:0]          i_time_ms,
    input  logic [qpv_pkg::INPUT_BITS-1:0]         i_count_a,
    input  logic [qpv_pkg::INPUT_BITS-1:0]         i_count_b,
    input  logic                                   i_clear_a,
    input  logic                                   i_clear_b,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [qpv_pkg::POS_BITS-1:0]    o_position_a,
    output logic signed [qpv_pkg::POS_BITS-1:0]    o_position_b,
    output logic signed [qpv_pkg::POS_BITS-1:0]    o_velocity_a,
    output logic signed [qpv_pkg::POS_BITS-1:0]    o_velocity_b,
    output logic                                   o_velocity_updated,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [qpv_pkg::CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [qpv_pkg::CFG_DATA_BITS-1:0]      i_cfg_data
);
    import qpv_pkg::*;

    logic [INTERVAL_BITS-1:0] r_interval;
    logic [SCALE_BITS-1:0]    r_scale;
    logic    job_valid, job_ready;
    t_job    job;
    t_result res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= INTERVAL_RESET;
            r_scale    <= SCALE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_INTERVAL: r_interval <= i_cfg_data[INTERVAL_BITS-1:0];
                REG_SCALE:    r_scale    <= i_cfg_data[SCALE_BITS-1:0];
                default: ;
            endcase
        end
    end

    qpv_front #(.COUNTER_BITS(COUNTER_BITS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_time_ms, .i_count_a,
        .i_count_b, .i_clear_a, .i_clear_b, .i_interval(r_interval),
        .o_job_valid(job_valid), .i_job_ready(job_ready), .o_job(job)
    );

    qpv_back u_back (
        .i_clk, .i_rst_n, .i_job_valid(job_valid), .o_job_ready(job_ready),
        .i_job(job), .i_scale(r_scale), .o_valid, .i_ready, .o_res(res)
    );

    assign o_position_a       = res.pos_a;
    assign o_position_b       = res.pos_b;
    assign o_velocity_a       = res.vel_a;
    assign o_velocity_b       = res.vel_b;
    assign o_velocity_updated = res.updated;

endmodule

[tb/quadrature_position_velocity_tb.sv]
// ----------------------------------------------------------------------------
// quadrature_position_velocity_tb
// Self-checking bench for the two-channel encoder position and velocity block.
// A short table of directed samples (reset state, step folding at the counter
// half range, clears, zero elapsed time, timestamp wrap) is followed by random
// encoder motion over several register settings and idle/stall mixes. Every
// result transfer is checked against its typed row or a behavioral predictor.
// ----------------------------------------------------------------------------
module quadrature_position_velocity_tb;

    import qpv_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 350;

    typedef struct {
        logic [TIME_BITS-1:0]  t;
        logic [INPUT_BITS-1:0] ca;
        logic [INPUT_BITS-1:0] cb;
        logic                  cla;
        logic                  clb;
        bit                    typed;
        t_result               res;
    } t_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    logic [TIME_BITS-1:0]      i_time_ms = '0;
    logic [INPUT_BITS-1:0]     i_count_a = '0;
    logic [INPUT_BITS-1:0]     i_count_b = '0;
    logic                      i_clear_a = 1'b0;
    logic                      i_clear_b = 1'b0;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic signed [POS_BITS-1:0] o_position_a;
    logic signed [POS_BITS-1:0] o_position_b;
    logic signed [POS_BITS-1:0] o_velocity_a;
    logic signed [POS_BITS-1:0] o_velocity_b;
    logic                      o_velocity_updated;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data = '0;

    quadrature_position_velocity dut (.*);

    // predictor state
    logic [INTERVAL_BITS-1:0] interval_ms = INTERVAL_RESET;
    logic [SCALE_BITS-1:0]    vel_scale = SCALE_RESET;
    logic [INPUT_BITS-1:0]    last_sample [2] = '{16'd0, 16'd0};
    logic [POS_BITS-1:0]      accum [2] = '{32'd0, 32'd0};
    logic [POS_BITS-1:0]      prev_accum [2] = '{32'd0, 32'd0};
    logic [POS_BITS-1:0]      speed [2] = '{32'd0, 32'd0};
    logic [TIME_BITS-1:0]     recalc_stamp = '0;

    t_result expected_results [$];
    int      errors = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      cycles = 0;

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic t_result predict_motion(input logic [TIME_BITS-1:0] now,
                                               input logic [INPUT_BITS-1:0] ca,
                                               input logic [INPUT_BITS-1:0] cb,
                                               input logic cla, input logic clb);
        t_result r;
        logic [INPUT_BITS-1:0] smp [2];
        logic clr [2];
        logic [TIME_BITS-1:0] elapsed;
        logic [POS_BITS-1:0] diff;
        int step;
        longint d;
        longint q;
        smp[0] = ca;
        smp[1] = cb;
        clr[0] = cla;
        clr[1] = clb;
        for (int ch = 0; ch < 2; ch++) begin
            if (clr[ch]) begin
                accum[ch] = '0;
                last_sample[ch] = '0;
                prev_accum[ch] = '0;
                speed[ch] = '0;
            end else begin
                step = int'({16'd0, smp[ch]}) - int'({16'd0, last_sample[ch]});
                if (step > 32767) step -= 65536;
                if (step < -32767) step += 65536;
                accum[ch] = accum[ch] + step;
                last_sample[ch] = smp[ch];
            end
        end
        elapsed = now - recalc_stamp;
        r.updated = 1'b0;
        if (elapsed != 0 && elapsed >= {16'd0, interval_ms}) begin
            recalc_stamp = now;
            for (int ch = 0; ch < 2; ch++) begin
                diff = accum[ch] - prev_accum[ch];
                d = $signed(diff);
                q = (d * longint'({44'd0, vel_scale})) / longint'({32'd0, elapsed});
                if (q > 64'sd2147483647) q = 64'sd2147483647;
                if (q < -64'sd2147483648) q = -64'sd2147483648;
                speed[ch] = q[31:0];
                prev_accum[ch] = accum[ch];
            end
            r.updated = 1'b1;
        end
        r.pos_a = accum[0];
        r.pos_b = accum[1];
        r.vel_a = speed[0];
        r.vel_b = speed[1];
        return r;
    endfunction

    // result side: check each transfer, then randomize the stall
    always @(posedge i_clk) begin
        t_result exp_r;
        if (o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result pos_a=%0d pos_b=%0d", $time,
                         o_position_a, o_position_b);
            end else begin
                exp_r = expected_results.pop_front();
                if (o_position_a !== exp_r.pos_a) begin
                    errors++;
                    $display("%0t: position_a exp %0d got %0d", $time, exp_r.pos_a,
                             o_position_a);
                end
                if (o_position_b !== exp_r.pos_b) begin
                    errors++;
                    $display("%0t: position_b exp %0d got %0d", $time, exp_r.pos_b,
                             o_position_b);
                end
                if (o_velocity_a !== exp_r.vel_a) begin
                    errors++;
                    $display("%0t: velocity_a exp %0d got %0d", $time, exp_r.vel_a,
                             o_velocity_a);
                end
                if (o_velocity_b !== exp_r.vel_b) begin
                    errors++;
                    $display("%0t: velocity_b exp %0d got %0d", $time, exp_r.vel_b,
                             o_velocity_b);
                end
                if (o_velocity_updated !== exp_r.updated) begin
                    errors++;
                    $display("%0t: velocity_updated exp %0b got %0b", $time,
                             exp_r.updated, o_velocity_updated);
                end
            end
        end
        if (i_rst_n) i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_sample(input t_row row);
        t_result pred;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_time_ms <= row.t;
        i_count_a <= row.ca;
        i_count_b <= row.cb;
        i_clear_a <= row.cla;
        i_clear_b <= row.clb;
        do @(posedge i_clk); while (!o_ready);
        pred = predict_motion(row.t, row.ca, row.cb, row.cla, row.clb);
        expected_results.push_back(row.typed ? row.res : pred);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_INTERVAL) interval_ms = data[INTERVAL_BITS-1:0];
        else vel_scale = data[SCALE_BITS-1:0];
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [INPUT_BITS-1:0] next_count(input logic [INPUT_BITS-1:0] c);
        int sel;
        sel = $urandom_range(99);
        if (sel < 60) return c + 16'($urandom_range(600) - 300);
        if (sel < 85) return c + 16'($urandom_range(65534) - 32767);
        return 16'($urandom);
    endfunction

    initial begin
        t_row dir_tab [14];
        t_row row;
        logic [TIME_BITS-1:0] now;
        logic [INPUT_BITS-1:0] raw_a;
        logic [INPUT_BITS-1:0] raw_b;
        int sel;

        dir_tab[0]  = '{32'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b1, '{0, 0, 0, 0, 1'b0}};
        dir_tab[1]  = '{32'd10, 16'd100, 16'hFFFF, 1'b0, 1'b0, 1'b1,
                        '{100, -1, 10000, -100, 1'b1}};
        dir_tab[2]  = '{32'd10, 16'd555, 16'hFFFF, 1'b1, 1'b0, 1'b1,
                        '{0, -1, 0, -100, 1'b0}};
        dir_tab[3]  = '{32'd15, 16'd32767, 16'd32767, 1'b0, 1'b0, 1'b0, '{0, 0, 0, 0, 0}};
        dir_tab[4]  = '{32'd20, 16'd0, 16'hFFFF, 1'b0, 1'b0, 1'b0, '{0, 0, 0, 0, 0}};
        dir_tab[5]  = '{32'd31, 16'd32768, 16'd32767, 1'b0, 1'b0, 1'b0, '{0, 0, 0, 0, 0}};
        dir_tab[6]  = '{32'd31, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, '{0, 0, 0, 0, 0}};
        dir_tab[7]  = '{32'd40, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b0, '{0, 0, 0, 0, 0}};
        dir_tab[8]  = '{32'hFFFF_FFFF, 16'h8001, 16'h7FFF, 1'b0, 1'b0, 1'b0,
                        '{0, 0, 0, 0, 0}};
        dir_tab[9]  = '{32'hFFFF_FFFF, 16'h0001, 16'hFFFE, 1'b0, 1'b0, 1'b0,
                        '{0, 0, 0, 0, 0}};
        dir_tab[10] = '{32'd5, 16'h5555, 16'hAAAA, 1'b0, 1'b0, 1'b0, '{0, 0, 0, 0, 0}};
        dir_tab[11] = '{32'd9, 16'hAAAA, 16'h5555, 1'b0, 1'b0, 1'b0, '{0, 0, 0, 0, 0}};
        dir_tab[12] = '{32'd100, 16'h1234, 16'h4321, 1'b1, 1'b1, 1'b0, '{0, 0, 0, 0, 0}};
        dir_tab[13] = '{32'd200, 16'h0100, 16'hFF00, 1'b0, 1'b0, 1'b0, '{0, 0, 0, 0, 0}};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[k]) send_sample(dir_tab[k]);
        wait_idle();

        now = 32'd200;
        raw_a = 16'h0100;
        raw_b = 16'hFF00;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_INTERVAL, 32'd0);
                    write_reg(REG_SCALE, 32'd1);
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                1: begin
                    write_reg(REG_INTERVAL, 32'd65535);
                    write_reg(REG_SCALE, 32'd1000000);
                    send_idle_pct = 51;
                    recv_idle_pct = 0;
                end
                2: begin
                    write_reg(REG_INTERVAL, 32'd5);
                    write_reg(REG_SCALE, 32'hFFFF_FFFF);
                    send_idle_pct = 0;
                    recv_idle_pct = 51;
                end
                default: begin
                    write_reg(REG_INTERVAL, 32'd1);
                    write_reg(REG_SCALE, 32'd0);
                    send_idle_pct = 25;
                    recv_idle_pct = 25;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 1 && n == 100) wait_idle();
                if (phase == 3 && n == 175) begin
                    wait_idle();
                    write_reg(REG_SCALE, 32'd1000000);
                end
                sel = $urandom_range(99);
                if (sel < 10) now = now;
                else if (sel < 75) now = now + $urandom_range(20, 1);
                else if (sel < 92) now = now + $urandom_range(200000, 60000);
                else now = $urandom;
                raw_a = next_count(raw_a);
                raw_b = next_count(raw_b);
                row.t = now;
                row.ca = raw_a;
                row.cb = raw_b;
                row.cla = ($urandom_range(99) < 3);
                row.clb = ($urandom_range(99) < 3);
                row.typed = 1'b0;
                row.res = '0;
                if (row.cla) raw_a = '0;
                if (row.clb) raw_b = '0;
                send_sample(row);
            end
            wait_idle();
        end

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/qpv_pkg.sv
rtl/core/qpv_front.sv
rtl/core/qpv_back.sv
rtl/core/quadrature_position_velocity.sv
tb/quadrature_position_velocity_tb.sv
